// ===== rtl/brr_pkg.sv =====
// ============================================================================
// brr_pkg
// Shared types and constants of the bitmap range reserve core: result codes
// and the command and status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package brr_pkg;

    // Block numbers and range ends are carried in this many bits.
    localparam int BLK_W = 12;

    localparam logic [1:0] ST_RESERVED     = 2'd0;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd1;
    localparam logic [1:0] ST_OCCUPIED     = 2'd2;
    localparam logic [1:0] ST_UNUSED       = 2'd3;

    localparam logic [10:0] TOTAL_BLOCKS_RESET = 11'd1024;

    typedef struct packed {
        logic       load;        // latch a new request
        logic       issue;       // read the map byte under the byte pointer
        logic       set_pass;    // the issued byte is to be written back
        logic       rewind;      // byte pointer back to the first byte
        logic       clear;       // write zero under the byte pointer
        logic       set_status;  // latch the result code
        logic [1:0] code;
    } cmd_t;

    typedef struct packed {
        logic oor;       // request at the input lies outside the pool
        logic zero;      // request at the input has a zero length
        logic at_last;   // byte pointer is on the last byte of the range
        logic clr_last;  // byte pointer is on the last byte of the map
        logic hit;       // some block of the range was found taken
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/bitmap_range_reserve_core.sv =====
// ============================================================================
// bitmap_range_reserve_core
// Bitmap allocator: reserves a run of consecutive blocks if all are free.
//
//   channel   signals                                 transfer when
//   request   start, busy, start_block, block_count   start && !busy
//   result    done, status                            done (one cycle)
//   config    cfg_valid, cfg_ready, cfg_data          cfg_valid && cfg_ready
//
// A request that is out of range or has a zero length is answered from idle
// without a map access. A request that finds a taken block stops after the
// check pass. A reservation runs a check pass and then a set pass over the map
// bytes the range touches: one map byte per cycle through the single read port
// in the check pass and again in the set.
// After reset all (MAX_BLOCKS+7)/8 map bytes are cleared, one byte per cycle,
// while busy is high; configuration writes are taken at any time.
// The result receiver cannot stall: status is valid only while done is high.
// ============================================================================
`default_nettype none

module bitmap_range_reserve_core
    import brr_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [9:0]  start_block,
    input  wire logic [10:0] block_count,
    output logic             done,
    output logic [1:0]       status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    brr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    brr_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .start_block (start_block),
        .block_count (block_count),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .sts         (sts),
        .status      (status)
    );

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != ST_UNUSED)
        else $error("result carries the unused status code");

endmodule

`default_nettype wire

// ===== rtl/brr_ram.sv =====
// ============================================================================
// brr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
`default_nettype none

module brr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/brr_ctrl.sv =====
// ============================================================================
// brr_ctrl
// Sequencer of the reserve core: clearing pass after reset, range decision,
// check pass and set pass over the map bytes, and the result strobe.
// ============================================================================
`default_nettype none

module brr_ctrl
    import brr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire sts_t sts,
    output cmd_t      cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_CHECK    = 7'b0000100,
        S_CHK_WAIT = 7'b0001000,
        S_SET      = 7'b0010000,
        S_SET_WAIT = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (sts.oor)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.code       = ST_OUT_OF_RANGE;
                        state_next     = S_DONE;
                    end
                    else if (sts.zero)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.code       = ST_RESERVED;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                cmd.issue = 1'b1;
                if (sts.at_last)
                begin
                    state_next = S_CHK_WAIT;
                end
            end
            S_CHK_WAIT:
            begin
                // The last byte of the check pass is compared in this cycle.
                if (sts.hit)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_OCCUPIED;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rewind = 1'b1;
                    state_next = S_SET;
                end
            end
            S_SET:
            begin
                cmd.issue    = 1'b1;
                cmd.set_pass = 1'b1;
                if (sts.at_last)
                begin
                    state_next = S_SET_WAIT;
                end
            end
            S_SET_WAIT:
            begin
                cmd.set_status = 1'b1;
                cmd.code       = ST_RESERVED;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not make the core busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe lasted more than one cycle");

    a_no_issue_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue || cmd.clear) |-> !done && busy)
        else $error("map access outside a pass");

endmodule

`default_nettype wire

// ===== rtl/brr_datapath.sv =====
// ============================================================================
// brr_datapath
// Pool size register, range check, byte pointer, per-byte masks and the
// occupancy map RAM with its one-deep read pipeline.
// ============================================================================
`default_nettype none

module brr_datapath
    import brr_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire logic [9:0]  start_block,
    input  wire logic [10:0] block_count,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_data,
    output sts_t             sts,
    output logic [1:0]       status
);

    localparam int MAP_BYTES = (MAX_BLOCKS + 7) / 8;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int MAXB_W    = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W     = (MAXB_W > BLK_W) ? MAXB_W : BLK_W;

    logic [10:0]       total_blocks_reg;
    logic [CMP_W-1:0]  limit;
    logic [BLK_W-1:0]  blk_end;
    logic [BLK_W-1:0]  blk_last;

    logic [2:0]        start_lo_reg;
    logic [2:0]        last_lo_reg;
    logic [ADDR_W-1:0] first_reg;
    logic [ADDR_W-1:0] last_reg;
    logic [ADDR_W-1:0] cur_reg;
    logic [ADDR_W-1:0] cur_next;
    logic              hit_reg;
    logic              hit_now;
    logic [1:0]        status_reg;

    logic              pipe_vld_reg;
    logic              pipe_set_reg;
    logic [ADDR_W-1:0] pipe_addr_reg;
    logic [7:0]        pipe_mask_reg;
    logic [7:0]        cur_mask;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    function automatic logic [ADDR_W-1:0] byte_index(input logic [BLK_W-1:0] blk);
        logic [ADDR_W+BLK_W-4:0] ext;
        ext = {{ADDR_W{1'b0}}, blk[BLK_W-1:3]};
        return ext[ADDR_W-1:0];
    endfunction

    // ---------------------------------------------------------------- range

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_blocks_reg <= TOTAL_BLOCKS_RESET;
        end
        else if (cfg_we)
        begin
            total_blocks_reg <= cfg_data;
        end
    end

    assign limit = (CMP_W'(total_blocks_reg) > CMP_W'(MAX_BLOCKS))
                 ? CMP_W'(MAX_BLOCKS) : CMP_W'(total_blocks_reg);
    assign blk_end  = BLK_W'(start_block) + BLK_W'(block_count);
    assign blk_last = blk_end - BLK_W'(1);

    assign sts.oor  = (CMP_W'(start_block) > limit) || (CMP_W'(blk_end) > limit);
    assign sts.zero = (block_count == '0);

    // ------------------------------------------------------------- pointers

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_lo_reg <= start_block[2:0];
            last_lo_reg  <= blk_last[2:0];
            first_reg    <= byte_index(BLK_W'(start_block));
            last_reg     <= byte_index(blk_last);
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.code;
        end
        pipe_addr_reg <= cur_reg;
        pipe_mask_reg <= cur_mask;
    end

    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.load)
        begin
            cur_next = byte_index(BLK_W'(start_block));
        end
        else if (cmd.rewind)
        begin
            cur_next = first_reg;
        end
        else if (cmd.issue || cmd.clear)
        begin
            cur_next = cur_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            hit_reg      <= 1'b0;
            pipe_vld_reg <= 1'b0;
            pipe_set_reg <= 1'b0;
        end
        else
        begin
            cur_reg      <= cur_next;
            hit_reg      <= cmd.load ? 1'b0 : hit_now;
            pipe_vld_reg <= cmd.issue;
            pipe_set_reg <= cmd.set_pass;
        end
    end

    assign sts.at_last  = (cur_reg == last_reg);
    assign sts.clr_last = (cur_reg == ADDR_W'(MAP_BYTES - 1));

    // Blocks of the range in the current byte; the lowest block is bit 7.
    always_comb
    begin
        logic [2:0] lo;
        logic [2:0] hi;
        lo = (cur_reg == first_reg) ? start_lo_reg : 3'd0;
        hi = (cur_reg == last_reg) ? last_lo_reg : 3'd7;
        for (int o = 0; o < 8; o++)
        begin
            cur_mask[7 - o] = (3'(o) >= lo) && (3'(o) <= hi);
        end
    end

    assign hit_now = hit_reg
                   || (pipe_vld_reg && !pipe_set_reg && ((ram_rdata & pipe_mask_reg) != '0));
    assign sts.hit = hit_now;

    // ------------------------------------------------------------------ map

    assign ram_we    = cmd.clear || (pipe_vld_reg && pipe_set_reg);
    assign ram_waddr = cmd.clear ? cur_reg : pipe_addr_reg;
    assign ram_wdata = cmd.clear ? 8'h00 : (ram_rdata | pipe_mask_reg);

    brr_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (cur_reg),
        .rdata (ram_rdata)
    );

    assign status = status_reg;

    // A write-back never targets the byte read in the same cycle.
    a_no_rmw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue && pipe_vld_reg && pipe_set_reg |-> cur_reg != pipe_addr_reg)
        else $error("set pass reads the byte it is writing");

    a_set_after_clean_check: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_vld_reg && pipe_set_reg |-> !hit_reg)
        else $error("set pass running after a taken block was found");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for bitmap_range_reserve_core. A scoreboard keeps its
// own occupancy bitmap and pool size and predicts the status of every request
// that the core takes. Each done strobe is checked against the oldest
// prediction. Stimulus is a directed set of edge cases followed by random
// phases under several pool sizes. Random gaps are placed on both the request
// and configuration channels.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import brr_pkg::*;

    localparam int MAP_BLOCKS = 1024;
    localparam int MAP_BYTES  = (MAP_BLOCKS + 7) / 8;

    class reserve_scoreboard;
        logic [7:0]  occ_map [0:MAP_BYTES-1];
        logic [10:0] pool_size;
        logic [1:0]  expected_status_q [$];
        int          n_errors;
        int          n_requests;
        int          n_reserved;
        int          n_out_of_range;
        int          n_occupied;
        int          n_pool_writes;

        function new();
            foreach (occ_map[i])
                occ_map[i] = 8'h00;
            pool_size = TOTAL_BLOCKS_RESET;
        endfunction

        function int pool_limit();
            return (pool_size > MAP_BLOCKS) ? MAP_BLOCKS : int'(pool_size);
        endfunction

        // Block 0 of each byte is the most significant bit.
        function bit block_taken(int blk);
            return occ_map[blk >> 3][7 - (blk & 7)];
        endfunction

        function void set_pool_size(logic [10:0] value);
            pool_size = value;
            n_pool_writes++;
        endfunction

        function void note_request(logic [9:0] first_blk, logic [10:0] num_blks);
            int         lim;
            int         first;
            int         last_end;
            bit         hit;
            logic [1:0] code;
            lim      = pool_limit();
            first    = int'(first_blk);
            last_end = first + int'(num_blks);
            hit      = 1'b0;
            if (first > lim || last_end > lim) begin
                code = ST_OUT_OF_RANGE;
                n_out_of_range++;
            end
            else begin
                for (int b = first; b < last_end; b++)
                    if (block_taken(b))
                        hit = 1'b1;
                if (hit) begin
                    code = ST_OCCUPIED;
                    n_occupied++;
                end
                else begin
                    for (int b = first; b < last_end; b++)
                        occ_map[b >> 3][7 - (b & 7)] = 1'b1;
                    code = ST_RESERVED;
                    n_reserved++;
                end
            end
            n_requests++;
            expected_status_q.push_back(code);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            n_errors++;
        endtask

        task check_status(logic [1:0] got);
            logic [1:0] want;
            if (expected_status_q.size() == 0) begin
                report_mismatch($sformatf("status %0d with no request outstanding", got));
            end
            else begin
                want = expected_status_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("status %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [9:0]  start_block = '0;
    logic [10:0] block_count = '0;
    logic        cfg_valid = 1'b0;
    logic [10:0] cfg_data = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic        cfg_ready;

    reserve_scoreboard sb = new();

    bitmap_range_reserve_core #(
        .MAX_BLOCKS(MAP_BLOCKS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .start_block(start_block),
        .block_count(block_count),
        .done       (done),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Results are checked before the request transfer of the same edge is
    // noted, so a back-to-back request never jumps ahead of its predecessor.
    always @(posedge clk) begin
        if (rst_n) begin
            if (done)
                sb.check_status(status);
            if (start && !busy)
                sb.note_request(start_block, block_count);
            if (cfg_valid && cfg_ready)
                sb.set_pool_size(cfg_data);
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task send_request(logic [9:0] first_blk, logic [10:0] num_blks, int gap);
        if (gap > 0) begin
            start       <= 1'b0;
            start_block <= 10'($urandom);
            block_count <= 11'($urandom);
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        start_block <= first_blk;
        block_count <= num_blks;
        do @(posedge clk); while (busy);
    endtask

    task write_pool_size(logic [10:0] value);
        int gap;
        gap = $urandom_range(3);
        repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // The extra edge lets the monitor note the last request transfer first.
    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_status_q.size() != 0 || busy)
            @(posedge clk);
    endtask

    task pick_item(output logic [9:0] first_blk, output logic [10:0] num_blks);
        int lim;
        int sel;
        int s;
        int b;
        int run;
        int i;
        bit found;
        lim   = sb.pool_limit();
        sel   = $urandom_range(99);
        found = 1'b0;
        b     = 0;
        // Aim at a free hole so the map keeps filling in varied patterns.
        if (sel < 35 && lim > 0) begin
            s = $urandom_range(lim - 1);
            i = 0;
            while (!found && i < lim) begin
                b = (s + i) % lim;
                if (!sb.block_taken(b))
                    found = 1'b1;
                i++;
            end
        end
        if (found) begin
            run = 0;
            while (b + run < lim && !sb.block_taken(b + run))
                run++;
            first_blk = 10'(b);
            if ($urandom_range(9) == 0)
                num_blks = 11'(run);
            else
                num_blks = 11'($urandom_range(1, (run < 4) ? run : 4));
        end
        else if (sel < 47) begin
            if ($urandom_range(3) == 0 && lim < MAP_BLOCKS)
                first_blk = 10'(lim);
            else
                first_blk = 10'($urandom_range(1023));
            num_blks = '0;
        end
        else if (sel < 77) begin
            first_blk = 10'($urandom_range(1023));
            num_blks  = 11'($urandom_range(1, 16));
        end
        else if (sel < 87) begin
            first_blk = (lim > 0) ? 10'($urandom_range(lim - 1)) : 10'd0;
            num_blks  = 11'($urandom_range(1024));
        end
        else begin
            s = (lim >= 4) ? lim - $urandom_range(3) : $urandom_range(3);
            first_blk = (s > 1023) ? 10'd1023 : 10'(s);
            num_blks  = 11'($urandom_range(2047));
        end
    endtask

    task run_phase(logic [10:0] pool, int num_items, bit quiet);
        logic [9:0]  first_blk;
        logic [10:0] num_blks;
        drain();
        write_pool_size(pool);
        repeat (num_items) begin
            pick_item(first_blk, num_blks);
            send_request(first_blk, num_blks, quiet ? 0 : pick_gap());
        end
    endtask

    initial begin
        logic [10:0] pools [8];
        pools = '{11'd1024, 11'd2047, 11'd513, 11'd1024, 11'd64, 11'd1023, 11'd8, 11'd1024};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Pool size still at its reset value.
        send_request(10'd0, 11'd0, pick_gap());
        send_request(10'd1023, 11'd1, pick_gap());

        // A pool size above the storage is clipped to it.
        drain();
        write_pool_size(11'd2047);
        send_request(10'd1023, 11'd1, pick_gap());
        send_request(10'd1022, 11'd2, pick_gap());
        send_request(10'd0, 11'd1, pick_gap());
        send_request(10'd0, 11'd1024, pick_gap());
        send_request(10'd1, 11'd7, pick_gap());
        send_request(10'd8, 11'd8, pick_gap());
        send_request(10'd5, 11'd6, pick_gap());
        send_request(10'd16, 11'd0, pick_gap());
        send_request(10'd1023, 11'd2, pick_gap());
        send_request(10'd1023, 11'd2047, pick_gap());
        send_request(10'd0, 11'd1025, pick_gap());
        send_request(10'd100, 11'd20, pick_gap());
        send_request(10'd1000, 11'd23, pick_gap());
        send_request(10'd512, 11'd1, pick_gap());

        // Empty pool: only a zero-length request at block 0 fits.
        drain();
        write_pool_size(11'd0);
        send_request(10'd0, 11'd0, pick_gap());
        send_request(10'd0, 11'd1, pick_gap());
        send_request(10'd1, 11'd0, pick_gap());

        // A start equal to the pool size passes only with a zero count.
        drain();
        write_pool_size(11'd200);
        send_request(10'd200, 11'd0, pick_gap());
        send_request(10'd150, 11'd50, pick_gap());
        send_request(10'd199, 11'd2, pick_gap());
        send_request(10'd201, 11'd0, pick_gap());

        for (int ph = 0; ph < 8; ph++)
            run_phase(pools[ph], 200, ph == 3);

        drain();
        repeat (300) @(posedge clk);

        $display("Covered %0d requests: %0d reserved, %0d out of range, %0d occupied.",
                 sb.n_requests, sb.n_reserved, sb.n_out_of_range, sb.n_occupied);
        $display("Pool size was rewritten %0d times, from empty to beyond the map size.",
                 sb.n_pool_writes);
        if (sb.n_errors == 0 && sb.expected_status_q.size() == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
